[rtl/core/rlc_pkg.sv]
// Shared types and constants for the RGB LED crossfade core.
// Item kinds, mood codes, colour constants and serial step counts.
// No dependencies.
`default_nettype none

package rlc_pkg;

  localparam int CH_W      = 8;
  localparam int TIME_W    = 16;
  localparam int STAMP_W   = 32;
  localparam int PROD_W    = TIME_W + CH_W;
  localparam int MUL_STEPS = CH_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [TIME_W-1:0] FADE_RESET = 16'd1000;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_SET  = 2'd1;
  localparam logic [1:0] KIND_MOOD = 2'd2;
  localparam logic [1:0] KIND_BEAT = 2'd3;

  localparam logic [2:0] MOOD_OFF   = 3'd0;
  localparam logic [2:0] MOOD_SWIRL = 3'd1;
  localparam logic [2:0] MOOD_RED   = 3'd3;

  localparam logic [CH_W-1:0] LEVEL_MAX = 8'd255;
  localparam logic [CH_W-1:0] LEVEL_MIN = 8'd0;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_MUL,
    LN_DIV,
    LN_DONE
  } lane_phase_t;

endpackage

`default_nettype wire

[rtl/core/rlc_lane.sv]
// One colour channel of the fade: bit-serial multiply then restoring divide.
// Gives from + floor(elapsed * (goal - from) / fade_time), floored toward minus infinity.
// Depends on rlc_pkg.
`default_nettype none

module rlc_lane import rlc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] elapsed,
  input  logic [CH_W-1:0]   from,
  input  logic [CH_W-1:0]   goal,
  input  logic [TIME_W-1:0] fade_time,
  output logic              done,
  output logic [CH_W-1:0]   level
);

  lane_phase_t       phase, phase_next;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] mcand;
  logic [CH_W-1:0]   mplier;
  logic [PROD_W-1:0] acc;
  logic [TIME_W-1:0] rem;
  logic              neg;
  logic [CH_W-1:0]   base;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              fits;
  logic              mul_last;
  logic              div_last;

  assign trial    = {rem, acc[PROD_W-1]};
  assign fits     = trial >= {1'b0, fade_time};
  assign diff     = trial - {1'b0, fade_time};
  assign mul_last = cnt == CNT_W'(MUL_STEPS - 1);
  assign div_last = cnt == CNT_W'(DIV_STEPS - 1);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      LN_IDLE: if (start) phase_next = LN_MUL;
      LN_MUL:  if (mul_last) phase_next = LN_DIV;
      LN_DIV:  if (div_last) phase_next = LN_DONE;
      LN_DONE: phase_next = LN_IDLE;
      default: phase_next = LN_IDLE;
    endcase
  end

  always_comb begin
    done  = phase == LN_DONE;
    level = neg ? base - acc[CH_W-1:0] - CH_W'(|rem) : base + acc[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= LN_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      LN_IDLE: begin
        if (start) begin
          cnt    <= '0;
          mcand  <= PROD_W'(elapsed);
          neg    <= goal < from;
          mplier <= (goal < from) ? from - goal : goal - from;
          acc    <= '0;
          rem    <= '0;
          base   <= from;
        end
      end
      LN_MUL: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[CH_W-1:1]};
        cnt    <= mul_last ? '0 : cnt + 1'b1;
      end
      LN_DIV: begin
        rem <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
        acc <= {acc[PROD_W-2:0], fits};
        cnt <= cnt + 1'b1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/rgb_led_crossfade_core.sv]
// Top level of the RGB LED crossfade core: item control, fade state, output register.
// Instantiates three rlc_lane channels; depends on rlc_pkg.
//
//  channel   direction  handshake            payload
//  in        request    in_valid / in_stall  kind, now_ms, mood_code, random_*, even_beat
//  out       result     out_valid/out_stall  red_level, green_level, blue_level
//  cfg       write      cfg_valid/cfg_ready  fade_time_ms
//
// One item at a time. Set-colour, store-mood and idle ticks return to idle from decide;
// beats and finished fades go on to emit, a running fade first to calc, where the three
// lanes spend 8 multiply and 24 divide steps in parallel. Reset is synchronous; no
// clearing pass. A waiting result stalls only the next result, not the next request.
`default_nettype none

module rgb_led_crossfade_core import rlc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [STAMP_W-1:0] now_ms,
  input  logic [2:0]         mood_code,
  input  logic [CH_W-1:0]    random_red,
  input  logic [CH_W-1:0]    random_green,
  input  logic [CH_W-1:0]    random_blue,
  input  logic               even_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CH_W-1:0]    red_level,
  output logic [CH_W-1:0]    green_level,
  output logic [CH_W-1:0]    blue_level,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TIME_W-1:0]  fade_time_ms
);

  state_t             state, state_next;
  logic [TIME_W-1:0]  fade_time;
  rgb_t               from, goal, res;
  logic [STAMP_W-1:0] fade_start;
  logic               fading;
  logic [2:0]         stored_mood;

  logic [1:0]         item_kind;
  logic [STAMP_W-1:0] item_now;
  logic [2:0]         item_mood;
  rgb_t               item_rand;
  logic               item_even;
  logic [STAMP_W-1:0] elapsed;

  logic               accept;
  logic               expired;
  logic               at_end;
  logic [2:0]         pick_mood;
  rgb_t               new_goal;
  logic               do_fade;
  logic               out_free;
  logic               lane_start;
  logic               lanes_done;
  rgb_t               lane_level;
  logic [2:0]         lane_done;

  assign cfg_ready = 1'b1;

  always_comb begin
    expired   = (elapsed[STAMP_W-1:TIME_W] != '0) || (elapsed[TIME_W-1:0] > fade_time);
    at_end    = elapsed[TIME_W-1:0] >= fade_time;
    pick_mood = (item_kind == KIND_SET) ? item_mood : MOOD_SWIRL;
    if (pick_mood == MOOD_OFF) begin
      new_goal = '{LEVEL_MIN, LEVEL_MIN, LEVEL_MIN};
    end else if (pick_mood == MOOD_RED) begin
      new_goal = '{LEVEL_MAX, LEVEL_MIN, LEVEL_MIN};
    end else begin
      new_goal = item_rand;
    end
    do_fade = (item_kind == KIND_SET) ||
              (item_kind == KIND_TICK && fading && expired && stored_mood == MOOD_SWIRL);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_DECIDE;
      ST_DECIDE: begin
        unique case (item_kind)
          KIND_TICK: begin
            if (!fading) state_next = ST_IDLE;
            else if (expired || at_end) state_next = ST_EMIT;
            else state_next = ST_CALC;
          end
          KIND_BEAT: state_next = ST_EMIT;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_CALC: if (lanes_done) state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = state != ST_IDLE;
    accept     = in_valid && !in_stall;
    out_free   = !out_valid || !out_stall;
    lane_start = state == ST_DECIDE && state_next == ST_CALC;
    lanes_done = &lane_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fade_time   <= FADE_RESET;
      from        <= '0;
      goal        <= '0;
      fade_start  <= '0;
      fading      <= 1'b0;
      stored_mood <= MOOD_OFF;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) fade_time <= fade_time_ms;
      if (state == ST_DECIDE) begin
        if (do_fade) begin
          from       <= goal;
          goal       <= new_goal;
          fade_start <= item_now;
          fading     <= 1'b1;
        end else if (item_kind == KIND_TICK && expired) begin
          fading <= 1'b0;
        end
        if (item_kind == KIND_MOOD) stored_mood <= item_mood;
      end
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind <= kind;
      item_now  <= now_ms;
      item_mood <= mood_code;
      item_rand <= '{random_red, random_green, random_blue};
      item_even <= even_beat;
      elapsed   <= now_ms - fade_start;
    end
    if (state == ST_DECIDE) begin
      if (item_kind == KIND_BEAT) begin
        res <= item_even ? {LEVEL_MIN, LEVEL_MAX, LEVEL_MAX}
                         : {LEVEL_MAX, LEVEL_MIN, LEVEL_MAX};
      end else if (do_fade && fade_time == '0) begin
        res <= new_goal;
      end else begin
        res <= goal;
      end
    end
    if (state == ST_CALC && lanes_done) res <= lane_level;
    if (state == ST_EMIT && out_free) begin
      red_level   <= res.red;
      green_level <= res.green;
      blue_level  <= res.blue;
    end
  end

  rlc_lane u_lane_red (
    .clk       (clk),
    .rst       (rst),
    .start     (lane_start),
    .elapsed   (elapsed[TIME_W-1:0]),
    .from      (from.red),
    .goal      (goal.red),
    .fade_time (fade_time),
    .done      (lane_done[0]),
    .level     (lane_level.red)
  );

  rlc_lane u_lane_green (
    .clk       (clk),
    .rst       (rst),
    .start     (lane_start),
    .elapsed   (elapsed[TIME_W-1:0]),
    .from      (from.green),
    .goal      (goal.green),
    .fade_time (fade_time),
    .done      (lane_done[1]),
    .level     (lane_level.green)
  );

  rlc_lane u_lane_blue (
    .clk       (clk),
    .rst       (rst),
    .start     (lane_start),
    .elapsed   (elapsed[TIME_W-1:0]),
    .from      (from.blue),
    .goal      (goal.blue),
    .fade_time (fade_time),
    .done      (lane_done[2]),
    .level     (lane_level.blue)
  );

endmodule

`default_nettype wire

[rtl/core/rlc_checker.sv]
// Port-level checks for the RGB LED crossfade core, bound to the top level.
// Depends on rlc_pkg and rgb_led_crossfade_core.
`default_nettype none

module rlc_assertions import rlc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         kind,
  input logic               even_beat,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CH_W-1:0]    red_level,
  input logic [CH_W-1:0]    green_level,
  input logic [CH_W-1:0]    blue_level
);

  logic req_accept;
  assign req_accept = in_valid && !in_stall;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red_level) &&
      $stable(green_level) && $stable(blue_level))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> in_stall)
    else $error("request taken while previous one in progress");

  a_beat_colour: assert property (@(posedge clk) disable iff (rst)
    req_accept && kind == KIND_BEAT && !out_valid |-> ##3
      (out_valid && blue_level == LEVEL_MAX &&
       green_level == ($past(even_beat, 3) ? LEVEL_MAX : LEVEL_MIN) &&
       red_level == ($past(even_beat, 3) ? LEVEL_MIN : LEVEL_MAX)))
    else $error("beat colour wrong or late");

endmodule

bind rgb_led_crossfade_core rlc_assertions u_rlc_assertions (.*);

`default_nettype wire
